// ----- rtl/five_point_stencil_matvec_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FIVE_POINT_STENCIL_MATVEC_UNIT_DEFINES_SVH
`define FIVE_POINT_STENCIL_MATVEC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define FPSMV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define FPSMV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fpsmv_pkg.sv -----
package fpsmv_pkg;

    localparam int MAX_WIDTH    = 32;
    localparam int INDEX_BITS   = 16;
    localparam int DATA_BITS    = 32;
    localparam int SUM_BITS     = 51;
    localparam int WIDTH_BITS   = 6;
    localparam int RING_DEPTH   = MAX_WIDTH + 1;
    localparam int SLOT_BITS    = $clog2(RING_DEPTH);
    localparam int COUNT_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int S_TDATA_BITS = 6 * DATA_BITS;
    localparam int M_TDATA_BITS = ((SUM_BITS + INDEX_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(4);

    typedef logic signed [DATA_BITS-1:0] data_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic [SLOT_BITS-1:0]        slot_t;
    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic [INDEX_BITS-1:0]       index_t;

    // One classified grid point as handed from the front to the back.
    typedef struct packed {
        data_t  value;
        data_t  coef_centre;
        data_t  coef_to_next_col;
        data_t  coef_to_prev_col;
        data_t  coef_to_next_row;
        data_t  coef_to_prev_row;
        logic   last_point;
        index_t point_index;
        slot_t  head;         // ring slot of this point
        logic   col_nz;       // not in the first column
        logic   above;        // a full row of earlier points exists
        logic   has_prev;     // at least one earlier point
        count_t flush_count;  // earlier points still pending, at most one row
        count_t width;        // effective row width
    } item_t;

endpackage

// ----- rtl/fpsmv_front.sv -----
module fpsmv_front
    import fpsmv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    s_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [WIDTH_BITS-1:0]   cfg_data,
    output logic                    push_valid,
    input  logic                    push_ready,
    output item_t                   push_item
);

    logic [WIDTH_BITS-1:0] width_reg;
    logic [COL_BITS-1:0]   col_reg;
    index_t                index_reg;
    slot_t                 head_reg;
    count_t                earlier_reg;

    count_t eff_width;
    count_t col_inc;
    logic   accept;

    assign cfg_ready  = 1'b1;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // Clamp the row width into the supported range
    always_comb begin
        if (width_reg == '0) begin
            eff_width = COUNT_BITS'(1);
        end else if (COUNT_BITS'(width_reg) > COUNT_BITS'(MAX_WIDTH)) begin
            eff_width = COUNT_BITS'(MAX_WIDTH);
        end else begin
            eff_width = COUNT_BITS'(width_reg);
        end
    end

    assign col_inc = COUNT_BITS'(col_reg) + COUNT_BITS'(1);

    // Unpack the point and tag it with its place in the grid
    always_comb begin
        push_item.value            = s_tdata[0*DATA_BITS +: DATA_BITS];
        push_item.coef_centre      = s_tdata[1*DATA_BITS +: DATA_BITS];
        push_item.coef_to_next_col = s_tdata[2*DATA_BITS +: DATA_BITS];
        push_item.coef_to_prev_col = s_tdata[3*DATA_BITS +: DATA_BITS];
        push_item.coef_to_next_row = s_tdata[4*DATA_BITS +: DATA_BITS];
        push_item.coef_to_prev_row = s_tdata[5*DATA_BITS +: DATA_BITS];
        push_item.last_point       = s_tlast;
        push_item.point_index      = index_reg;
        push_item.head             = head_reg;
        push_item.col_nz           = (col_reg != '0);
        push_item.above            = (earlier_reg >= eff_width);
        push_item.has_prev         = (earlier_reg != '0);
        push_item.flush_count      = (earlier_reg >= eff_width) ? eff_width : earlier_reg;
        push_item.width            = eff_width;
    end

    // Track grid position; restart on a width write or after the last point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            col_reg     <= '0;
            index_reg   <= '0;
            head_reg    <= '0;
            earlier_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            width_reg   <= cfg_data;
            col_reg     <= '0;
            index_reg   <= '0;
            head_reg    <= '0;
            earlier_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                col_reg     <= '0;
                index_reg   <= '0;
                head_reg    <= '0;
                earlier_reg <= '0;
            end else begin
                col_reg   <= (col_inc >= eff_width) ? '0 : COL_BITS'(col_inc);
                index_reg <= index_reg + INDEX_BITS'(1);
                head_reg  <= (head_reg == slot_t'(RING_DEPTH - 1)) ?
                             '0 : head_reg + slot_t'(1);
                if (earlier_reg < eff_width) begin
                    earlier_reg <= earlier_reg + COUNT_BITS'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/fpsmv_queue.sv -----
module fpsmv_queue
    import fpsmv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t                store_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Hold entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QPTR_BITS+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QPTR_BITS+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/fpsmv_back.sv -----
module fpsmv_back
    import fpsmv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  item_t                   pop_item,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_RD,
        S_OUT
    } state_t;

    // Q16.16 by Q16.16, floor-truncated to Q32.16, wrapped to the sum width
    function automatic sum_t q_product(data_t a, data_t b);
        logic signed [2*DATA_BITS-1:0] p;
        p = a * b;
        return SUM_BITS'(p >>> 16);
    endfunction

    // Ring slot a given number of points behind the head
    function automatic slot_t slot_back(slot_t head, count_t back);
        logic [SLOT_BITS:0] diff;
        diff = {1'b0, head} - (SLOT_BITS+1)'(back);
        if (diff[SLOT_BITS]) begin
            diff = diff + (SLOT_BITS+1)'(RING_DEPTH);
        end
        return diff[SLOT_BITS-1:0];
    endfunction

    state_t state_reg;
    item_t  work_reg;
    sum_t   pc_reg;
    sum_t   pnc_reg;
    sum_t   ppc_reg;
    sum_t   pnr_reg;
    sum_t   ppr_reg;
    sum_t   n_rd_reg;
    sum_t   p_rd_reg;
    sum_t   carry_reg;
    sum_t   cur_reg;
    sum_t   pprev_reg;
    count_t back_reg;
    logic   m_tvalid_reg;
    sum_t   out_value_reg;
    index_t out_index_reg;
    logic   out_last_reg;

    // Partial sums still waiting for the row below, and row-down contributions
    sum_t   p_mem [RING_DEPTH];
    sum_t   n_mem [RING_DEPTH];

    sum_t   cur_sum;
    sum_t   pprev_sum;
    sum_t   sel_sum;
    sum_t   out_sum;
    logic   out_free;
    logic   n_we;
    logic   p_we;

    assign pop_ready = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Accumulate the point's own sum and finish its left neighbour's partial
    assign cur_sum   = pc_reg + (work_reg.col_nz ? carry_reg : '0)
                     + (work_reg.above ? n_rd_reg : '0);
    assign pprev_sum = cur_reg + (work_reg.col_nz ? ppc_reg : '0);

    // Pick the pending sum for the point being sent
    always_comb begin
        if (back_reg == '0) begin
            sel_sum = cur_reg;
        end else if (back_reg == COUNT_BITS'(1)) begin
            sel_sum = pprev_reg;
        end else begin
            sel_sum = p_rd_reg;
        end
        out_sum = sel_sum + ((back_reg == work_reg.width) ? ppr_reg : '0);
    end

    assign n_we = (state_reg == S_ACC) && !work_reg.last_point;
    assign p_we = (state_reg == S_ACC) && work_reg.has_prev;

    // Ring writes
    always_ff @(posedge aclk) begin
        if (n_we) begin
            n_mem[work_reg.head] <= pnr_reg;
        end
        if (p_we) begin
            p_mem[slot_back(work_reg.head, COUNT_BITS'(1))] <= pprev_sum;
        end
    end

    // Ring reads, registered
    always_ff @(posedge aclk) begin
        if (state_reg == S_MUL) begin
            n_rd_reg <= n_mem[slot_back(work_reg.head, work_reg.width)];
        end
        if (state_reg == S_RD) begin
            p_rd_reg <= p_mem[slot_back(work_reg.head, back_reg)];
        end
    end

    // Sequencer: multiply, accumulate, then read and send pending sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop the sent result unless a new one replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop_valid) begin
                        work_reg  <= pop_item;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    pc_reg    <= q_product(work_reg.value, work_reg.coef_centre);
                    pnc_reg   <= q_product(work_reg.value, work_reg.coef_to_next_col);
                    ppc_reg   <= q_product(work_reg.value, work_reg.coef_to_prev_col);
                    pnr_reg   <= q_product(work_reg.value, work_reg.coef_to_next_row);
                    ppr_reg   <= q_product(work_reg.value, work_reg.coef_to_prev_row);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    cur_reg   <= cur_sum;
                    pprev_reg <= pprev_sum;
                    carry_reg <= pnc_reg;
                    if (work_reg.last_point) begin
                        back_reg  <= work_reg.flush_count;
                        state_reg <= S_RD;
                    end else if (work_reg.above) begin
                        back_reg  <= work_reg.width;
                        state_reg <= S_RD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        out_value_reg <= out_sum;
                        out_index_reg <= work_reg.point_index - INDEX_BITS'(back_reg);
                        out_last_reg  <= work_reg.last_point && (back_reg == '0);
                        if (work_reg.last_point && (back_reg != '0)) begin
                            back_reg  <= back_reg - COUNT_BITS'(1);
                            state_reg <= S_RD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_BITS - SUM_BITS - INDEX_BITS){1'b0}},
                       out_index_reg, out_value_reg};

endmodule

// ----- rtl/five_point_stencil_matvec_unit.sv -----
// Five-point stencil matrix-vector product over a streamed grid.
// s_ channel: one grid point per transfer in row-major order; tdata carries the
//   value and five Q16.16 coefficients, tlast marks the final point of the grid.
// m_ channel: one finished Q35.16 sum per transfer with its row-major index;
//   tlast marks the final result of the grid.
// cfg_ channel: writes grid_width (points per row, 0 acts as 1, above 32 as 32)
//   and restarts the stream; write only while the block is idle.
// A point's result leaves once the point one row below has been taken in and
//   has passed the back end's multiply, accumulate, ring-read and output states.
// The back end takes each point through its multiply and accumulate states, and
//   a point that completes a result also through a ring read and an output step;
//   it takes no new point until it is back in idle. The last point adds a ring
//   read and an output step for each flushed result (up to one row plus itself),
//   and an output step waits while m_tready holds the result.
// A two-entry queue lets the input side take points while the back end works.
// Reset (aresetn low, synchronous) empties the queue and output, sets the
//   width to 4 and restarts at index 0; the sum ring needs no clearing pass.
// When m_tready is low the result is held, and the input side keeps accepting
//   until the queue is full.
module five_point_stencil_matvec_unit
    import fpsmv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // value, coef_centre, coef_to_next_col, coef_to_prev_col,
    // coef_to_next_row, coef_to_prev_row (32 bits each, lowest first)
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // product_value [50:0], point_index [66:51], zero fill above
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [WIDTH_BITS-1:0]   cfg_data
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    fpsmv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fpsmv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fpsmv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/fpsmv_checker.sv -----
`include "five_point_stencil_matvec_unit_defines.svh"

module fpsmv_checker
    import fpsmv_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata,
    input logic                    m_tlast
);

    // A stalled result holds its payload
    `FPSMV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // Nothing is offered in the cycle after reset
    `FPSMV_ASSERT_NOW(a_reset_empty, aclk, aresetn, $past(!aresetn),
        !m_tvalid, "result valid right after reset")

    // The input side only fills up by taking a transfer
    `FPSMV_ASSERT_NOW(a_ready_drop, aclk, aresetn, $fell(s_tready),
        $past(s_tvalid), "input ready dropped without a transfer")

endmodule

bind five_point_stencil_matvec_unit fpsmv_checker u_checker (.*);
